// ----- hw/rtl/bsd_pkg.sv -----
package bsd_pkg;

    localparam int CHANNELS = 8;
    localparam int BASE_W   = 18;
    localparam int RUN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 8;
    localparam int CFG_W    = 18;
    localparam int CFG_AW   = 2;
    localparam int IN_W     = CHANNELS * BASE_W;
    localparam int OUT_W    = 16;

    localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};
    localparam logic [RUN_W-1:0] RUN_ONE   = RUN_W'(1);
    localparam logic [RUN_W-1:0] MIN_COUNT = RUN_W'(2);

    localparam logic [MASK_W-1:0] MASK_RST  = {MASK_W{1'b1}};
    localparam logic [BASE_W-1:0] TOL_RST   = BASE_W'(16);
    localparam logic [RUN_W-1:0]  COUNT_RST = RUN_W'(2);

    typedef logic [BASE_W-1:0] t_base;

    typedef enum logic [STATUS_W-1:0] {
        ST_COLLECT = 2'd0,
        ST_SETTLED = 2'd1,
        ST_FAIL    = 2'd2,
        ST_BAD_CFG = 2'd3
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        REG_MASK  = 2'd0,
        REG_TOL   = 2'd1,
        REG_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_status          status;
        logic [RUN_W-1:0] run_length;
    } t_result;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        t_base             tol;
        logic [RUN_W-1:0]  count;
    } t_cfg;

endpackage

// ----- hw/rtl/bsd_lane.sv -----
module bsd_lane (
    input  logic          i_clk,
    input  logic          i_upd,
    input  logic          i_en,
    input  bsd_pkg::t_base i_cur,
    input  bsd_pkg::t_base i_tol,
    output logic          o_ok
);
    import bsd_pkg::*;

    t_base r_prev;
    t_base diff;

    always_comb begin
        if (i_cur > r_prev) begin
            diff = i_cur - r_prev;
        end else begin
            diff = r_prev - i_cur;
        end
        o_ok = !i_en || (diff <= i_tol);
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_prev <= i_cur;
        end
    end

endmodule

// ----- hw/rtl/bsd_merge.sv -----
module bsd_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_start,
    input  logic                           i_last,
    input  logic [bsd_pkg::CHANNELS-1:0]   i_ok,
    input  bsd_pkg::t_cfg                  i_cfg,
    output logic                           o_upd,
    output bsd_pkg::t_result               o_res
);
    import bsd_pkg::*;

    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run;
    logic             r_settled;
    logic             n_settled;
    logic [RUN_W-1:0] run_step;
    logic             cfg_bad;
    logic             stable;

    always_comb begin
        cfg_bad   = (i_cfg.mask[CHANNELS-1:0] == '0) || (i_cfg.count < MIN_COUNT);
        stable    = &i_ok;
        run_step  = stable ? ((r_run < RUN_MAX) ? r_run + RUN_ONE : r_run) : RUN_ONE;
        n_run     = r_run;
        n_settled = r_settled;
        o_upd     = 1'b0;
        o_res.status     = ST_BAD_CFG;
        o_res.run_length = r_run;
        if (cfg_bad) begin
            o_res.status = ST_BAD_CFG;
        end else if (i_start || r_run == '0) begin
            o_upd            = 1'b1;
            n_settled        = 1'b0;
            o_res.run_length = RUN_ONE;
            o_res.status     = i_last ? ST_FAIL : ST_COLLECT;
            n_run            = i_last ? '0 : RUN_ONE;
        end else if (r_settled) begin
            o_res.status = ST_SETTLED;
        end else begin
            o_upd            = 1'b1;
            o_res.run_length = run_step;
            if (run_step >= i_cfg.count) begin
                n_settled    = 1'b1;
                o_res.status = ST_SETTLED;
                n_run        = run_step;
            end else begin
                o_res.status = i_last ? ST_FAIL : ST_COLLECT;
                n_run        = i_last ? '0 : run_step;
            end
        end
        o_upd = o_upd && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_settled <= 1'b0;
        end else if (i_accept) begin
            r_run     <= n_run;
            r_settled <= n_settled;
        end
    end

endmodule

// ----- hw/rtl/baseline_settling_detector.sv -----
// Results are registered in the output entry, or in the skid entry when it is full.
// Throughput: one measurement per cycle while o_s_tready is high; the run
// counter and the stored baselines update in the same cycle, from eight compare
// lanes and one merge. A two-entry output stage keeps input ready while one
// result waits. Reset (synchronous, active low) clears the run state and
// output valids and restores mask 255, tolerance 16, stable count 2.
module baseline_settling_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bsd_pkg::IN_W-1:0]      i_s_tdata,   // ch0_baseline .. ch7_baseline
    input  logic                          i_s_tlast,   // last
    input  logic                          i_s_tuser,   // start_req
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bsd_pkg::OUT_W-1:0]     o_m_tdata,   // status, run_length, zero pad
    input  logic                          i_cfg_we,
    input  logic [bsd_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [bsd_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import bsd_pkg::*;

    t_cfg                r_cfg;
    t_result             res;
    t_result             r_out_res;
    t_result             n_out_res;
    t_result             r_skid_res;
    t_result             n_skid_res;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_skid_valid;
    logic                n_skid_valid;
    logic                s_accept;
    logic                m_take;
    logic                upd;
    logic [CHANNELS-1:0] ok;

    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_take     = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - RUN_W - STATUS_W){1'b0}},
                         r_out_res.run_length, r_out_res.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask  <= MASK_RST;
            r_cfg.tol   <= TOL_RST;
            r_cfg.count <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MASK:  r_cfg.mask  <= i_cfg_wdata[MASK_W-1:0];
                REG_TOL:   r_cfg.tol   <= i_cfg_wdata[BASE_W-1:0];
                REG_COUNT: r_cfg.count <= i_cfg_wdata[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        bsd_lane u_lane (
            .i_clk (i_clk),
            .i_upd (upd),
            .i_en  (r_cfg.mask[c]),
            .i_cur (i_s_tdata[c*BASE_W +: BASE_W]),
            .i_tol (r_cfg.tol),
            .o_ok  (ok[c])
        );
    end

    bsd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_start  (i_s_tuser),
        .i_last   (i_s_tlast),
        .i_ok     (ok),
        .i_cfg    (r_cfg),
        .o_upd    (upd),
        .o_res    (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_res    = r_out_res;
        n_skid_valid = r_skid_valid;
        n_skid_res   = r_skid_res;
        if (m_take) begin
            n_out_valid = 1'b0;
        end
        if (!n_out_valid && r_skid_valid) begin
            n_out_res    = r_skid_res;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end
        if (s_accept) begin
            if (!n_out_valid) begin
                n_out_res   = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid_res   = res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res  <= n_out_res;
        r_skid_res <= n_skid_res;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_out_valid)
        else $error("accepted transaction produced no output");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && res.status != ST_BAD_CFG) |-> (res.run_length != '0))
        else $error("zero run length on a valid step");

endmodule
